>>> src/mlcs_pkg.sv
`default_nettype none

package mlcs_pkg;

  localparam int unsigned TagFieldW = 20;

  typedef enum logic [1:0] {
    CmdLookup   = 2'd0,
    CmdSetState = 2'd1,
    CmdInsert   = 2'd2,
    CmdRefresh  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MesiM = 2'd0,
    MesiE = 2'd1,
    MesiS = 2'd2,
    MesiI = 2'd3
  } mesi_e;

  typedef struct packed {
    cmd_e                 cmd;
    logic [TagFieldW-1:0] tag;
    mesi_e                new_state;
  } req_t;

  typedef struct packed {
    mesi_e found_state;
    logic  hit;
    logic  evicted;
    logic  writeback;
    logic  miss_error;
  } rsp_t;

  typedef struct packed {
    logic  wr_state;
    logic  fill;
    logic  promote;
    mesi_e state;
  } line_upd_t;

endpackage

`default_nettype wire

>>> src/mesi_lru_cache_set_unit.sv
`default_nettype none

// Each word is registered into req_q at the accepting edge; its result is then registered into
// rsp_q together with done_q, and appears on rsp_o with done_o high for exactly one cycle.
// A new word can be accepted every cycle, so busy is never asserted; the receiver cannot stall.
// Throughput is one word per cycle, set by the single pass through the way compare and
// recency update. After reset all lines are invalid in state I with rank equal to way index.
module mesi_lru_cache_set_unit #(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned TAG_BITS = 20
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire mlcs_pkg::req_t req_i,
  output logic                done_o,
  output mlcs_pkg::rsp_t      rsp_o
);

  import mlcs_pkg::*;

  localparam int unsigned TagW  = (TAG_BITS < TagFieldW) ? TAG_BITS : TagFieldW;
  localparam int unsigned RankW = (WAYS > 1) ? $clog2(WAYS) : 1;

  req_t             req_q;
  logic             req_vld_q;
  rsp_t             rsp_d;
  rsp_t             rsp_q;
  logic             done_q;

  logic [TagW-1:0]  tag_w   [WAYS];
  logic [WAYS-1:0]  valid_w;
  mesi_e            mesi_w  [WAYS];
  logic [RankW-1:0] rank_w  [WAYS];

  logic [WAYS-1:0]  match_cand;
  logic [WAYS-1:0]  inv_cand;
  logic [WAYS-1:0]  idle_cand;
  logic [WAYS-1:0]  lru_way;
  logic [WAYS-1:0]  match_sel;
  logic [WAYS-1:0]  inv_sel;
  logic [WAYS-1:0]  idle_sel;
  logic             match_any;
  logic             inv_any;
  logic             idle_any;
  logic [1:0]       match_mesi;
  logic [1:0]       lru_mesi;

  logic [WAYS-1:0]  way_sel;
  line_upd_t        upd;

  assign busy = 1'b0;

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      req_vld_q <= start;
      done_q    <= req_vld_q;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match_cand[w] = valid_w[w] && (tag_w[w] == req_q.tag[TagW-1:0]);
      inv_cand[w]   = ~valid_w[w];
      idle_cand[w]  = (mesi_w[w] == MesiI);
      lru_way[w]    = (rank_w[w] == RankW'(WAYS - 1));
    end
  end

  mlcs_pick #(.WAYS(WAYS), .RankW(RankW)) u_pick_match (
    .cand_i (match_cand),
    .rank_i (rank_w),
    .sel_o  (match_sel),
    .any_o  (match_any)
  );

  mlcs_pick #(.WAYS(WAYS), .RankW(RankW)) u_pick_inv (
    .cand_i (inv_cand),
    .rank_i (rank_w),
    .sel_o  (inv_sel),
    .any_o  (inv_any)
  );

  mlcs_pick #(.WAYS(WAYS), .RankW(RankW)) u_pick_idle (
    .cand_i (idle_cand),
    .rank_i (rank_w),
    .sel_o  (idle_sel),
    .any_o  (idle_any)
  );

  always_comb begin
    match_mesi = '0;
    lru_mesi   = '0;
    for (int w = 0; w < WAYS; w++) begin
      match_mesi = match_mesi | (mesi_w[w] & {2{match_sel[w]}});
      lru_mesi   = lru_mesi | (mesi_w[w] & {2{lru_way[w]}});
    end
  end

  always_comb begin
    rsp_d             = '0;
    rsp_d.found_state = MesiI;
    upd               = '0;
    upd.state         = req_q.new_state;
    way_sel           = match_sel;
    case (req_q.cmd)
      CmdLookup: begin
        rsp_d.hit = match_any;
        if (match_any) begin
          rsp_d.found_state = mesi_e'(match_mesi);
        end
      end
      CmdSetState: begin
        rsp_d.hit    = match_any;
        upd.wr_state = req_vld_q && match_any;
        upd.promote  = req_vld_q && match_any && (req_q.new_state != MesiI);
      end
      CmdRefresh: begin
        rsp_d.hit        = match_any;
        rsp_d.miss_error = ~match_any;
        upd.wr_state     = req_vld_q && match_any;
        upd.promote      = req_vld_q && match_any;
      end
      default: begin
        if (inv_any) begin
          way_sel = inv_sel;
        end else if (idle_any) begin
          way_sel = idle_sel;
        end else begin
          way_sel         = lru_way;
          rsp_d.evicted   = 1'b1;
          rsp_d.writeback = (mesi_e'(lru_mesi) == MesiM);
        end
        upd.fill     = req_vld_q;
        upd.wr_state = req_vld_q;
        upd.promote  = req_vld_q;
      end
    endcase
  end

  mlcs_lines #(.WAYS(WAYS), .TagW(TagW), .RankW(RankW)) u_lines (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .way_sel_i (way_sel),
    .upd_i     (upd),
    .tag_i     (req_q.tag[TagW-1:0]),
    .tag_o     (tag_w),
    .valid_o   (valid_w),
    .mesi_o    (mesi_w),
    .rank_o    (rank_w)
  );

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

>>> src/mlcs_pick.sv
`default_nettype none

module mlcs_pick #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned RankW = 3
) (
  input  wire logic [WAYS-1:0]  cand_i,
  input  wire logic [RankW-1:0] rank_i [WAYS],
  output logic      [WAYS-1:0]  sel_o,
  output logic                  any_o
);

  // The selected way is the candidate that no other candidate precedes in recency order.
  always_comb begin
    logic blocked;
    for (int w = 0; w < WAYS; w++) begin
      blocked = 1'b0;
      for (int k = 0; k < WAYS; k++) begin
        if (cand_i[k] && (rank_i[k] < rank_i[w])) begin
          blocked = 1'b1;
        end
      end
      sel_o[w] = cand_i[w] & ~blocked;
    end
  end

  assign any_o = |cand_i;

endmodule

`default_nettype wire

>>> src/mlcs_lines.sv
`default_nettype none

module mlcs_lines #(
  parameter int unsigned WAYS  = 8,
  parameter int unsigned TagW  = 20,
  parameter int unsigned RankW = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [WAYS-1:0]     way_sel_i,
  input  wire mlcs_pkg::line_upd_t upd_i,
  input  wire logic [TagW-1:0]     tag_i,
  output logic      [TagW-1:0]     tag_o   [WAYS],
  output logic      [WAYS-1:0]     valid_o,
  output mlcs_pkg::mesi_e          mesi_o  [WAYS],
  output logic      [RankW-1:0]    rank_o  [WAYS]
);

  import mlcs_pkg::*;

  logic  [TagW-1:0]  tag_q   [WAYS];
  logic  [WAYS-1:0]  valid_q;
  mesi_e             mesi_q  [WAYS];
  logic  [RankW-1:0] rank_q  [WAYS];
  logic  [RankW-1:0] sel_rank;

  always_comb begin
    sel_rank = '0;
    for (int w = 0; w < WAYS; w++) begin
      sel_rank = sel_rank | (rank_q[w] & {RankW{way_sel_i[w]}});
    end
  end

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAYS; w++) begin
      if (upd_i.fill && way_sel_i[w]) begin
        tag_q[w] <= tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int w = 0; w < WAYS; w++) begin
        mesi_q[w] <= MesiI;
        rank_q[w] <= RankW'(w);
      end
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (upd_i.fill && way_sel_i[w]) begin
          valid_q[w] <= 1'b1;
        end
        if (upd_i.wr_state && way_sel_i[w]) begin
          mesi_q[w] <= upd_i.state;
        end
        if (upd_i.promote) begin
          if (way_sel_i[w]) begin
            rank_q[w] <= '0;
          end else if (rank_q[w] < sel_rank) begin
            rank_q[w] <= rank_q[w] + RankW'(1);
          end
        end
      end
    end
  end

  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign mesi_o  = mesi_q;
  assign rank_o  = rank_q;

endmodule

`default_nettype wire
